// ----- hdl/streaming_multiply_xorshift_hash_core_assert.svh -----
// Assertion macros shared by the hash core RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef STREAMING_MULTIPLY_XORSHIFT_HASH_CORE_ASSERT_SVH
`define STREAMING_MULTIPLY_XORSHIFT_HASH_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define SMXH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smxh: same-cycle implication violated");
// Next-cycle implication, checked at every rising edge out of reset.
`define SMXH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smxh: next-cycle implication violated");
`else
`define SMXH_ASSERT_IMPL(label, ante, cons)
`define SMXH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/smxh_pkg.sv -----
// Shared types and constants for the multiply/xorshift hash core.
// No dependencies; imported by every module of the core.
package smxh_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [WORD_W-1:0] GOLDEN_CONST = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WORD_W-1:0] WORD_MULT    = 64'hff51_afd7_ed55_8ccd;
  localparam logic [WORD_W-1:0] FINAL_MULT   = 64'hc4ce_b9fe_1a85_ec53;
  localparam int unsigned MIX_SHIFT = 33;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  // Work handed from the front end to the mixing back end.
  typedef enum logic [1:0] {
    OP_START,
    OP_MIX_WORD,
    OP_MIX_FINAL
  } smxh_op_t;

  typedef struct packed {
    smxh_op_t          op;
    logic [WORD_W-1:0] data;
  } smxh_entry_t;

endpackage

// ----- hdl/streaming_multiply_xorshift_hash_core.sv -----
// Top level of the streaming multiply/xorshift 64-bit hash core.
// Depends on smxh_pkg, smxh_queue, smxh_front, smxh_back and the assertion header.
//
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_mode, in_data_byte, in_seed, in_length
// out_      output     out_valid/out_stall out_hash_value (one per finish transaction)
//
// Data bytes are taken one per cycle; the byte stream never waits on the mixer
// as long as the queue has room. The back end takes a start while idle; a full
// word or finish forms the partial products while idle, then the sum and
// xorshift in the mix state, popping nothing until the accumulator is updated.
// Reset is synchronous and clears the accumulator, the partial word and the
// queue. A stalled digest holds the back end; the queue then fills, raising in_stall.
`include "streaming_multiply_xorshift_hash_core_assert.svh"

module streaming_multiply_xorshift_hash_core #(
  parameter int unsigned QUEUE_DEPTH = smxh_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_seed,
  input  logic [63:0] in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);
  import smxh_pkg::*;

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  smxh_entry_t push_entry;
  smxh_entry_t pop_entry;

  smxh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .in_seed      (in_seed),
    .in_length    (in_length),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  smxh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  smxh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  // A transaction that needs mixing must never be written into a full queue.
  `SMXH_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full)
  `SMXH_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_empty)
  `SMXH_ASSERT_IMPL(a_finish_queued,
      in_valid && !in_stall && (in_mode == MODE_FINISH), q_push)
  `SMXH_ASSERT_NEXT(a_start_pending,
      in_valid && !in_stall && (in_mode == MODE_START), !q_empty)

endmodule

// ----- hdl/smxh_queue.sv -----
// Small register queue between the front end and the back end.
// Depends on smxh_pkg for the entry type.
module smxh_queue #(
  parameter int unsigned DEPTH = smxh_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  smxh_pkg::smxh_entry_t push_entry,
  input  logic                 pop,
  output smxh_pkg::smxh_entry_t pop_entry,
  output logic                 full,
  output logic                 empty
);
  import smxh_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  smxh_entry_t      slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- hdl/smxh_front.sv -----
// Front end: accepts transactions, packs bytes into words, and queues mix work.
// Depends on smxh_pkg for modes, constants and the entry type.
module smxh_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_data_byte,
  input  logic [63:0]           in_seed,
  input  logic [63:0]           in_length,
  input  logic                  q_full,
  output logic                  q_push,
  output smxh_pkg::smxh_entry_t q_entry
);
  import smxh_pkg::*;

  logic [WORD_W-1:0] partial_r, partial_nxt;
  logic [2:0]        count_r, count_nxt;
  logic [WORD_W-1:0] merged;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign merged   = partial_r | ({{(WORD_W-BYTE_W){1'b0}}, in_data_byte} << {count_r, 3'b000});

  always_comb begin
    partial_nxt  = partial_r;
    count_nxt    = count_r;
    q_push       = 1'b0;
    q_entry.op   = OP_START;
    q_entry.data = in_seed ^ (GOLDEN_CONST + in_length);
    if (accept) begin
      unique case (in_mode)
        MODE_START: begin
          q_push      = 1'b1;
          partial_nxt = '0;
          count_nxt   = '0;
        end
        MODE_DATA: begin
          if (count_r == 3'd7) begin
            // Eighth byte completes a word; hand it to the back end.
            q_push       = 1'b1;
            q_entry.op   = OP_MIX_WORD;
            q_entry.data = merged;
            partial_nxt  = '0;
            count_nxt    = '0;
          end else begin
            partial_nxt = merged;
            count_nxt   = 3'(count_r + 3'd1);
          end
        end
        MODE_FINISH: begin
          // The partial word stays as it is after a finish.
          q_push       = 1'b1;
          q_entry.op   = OP_MIX_FINAL;
          q_entry.data = partial_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      count_r   <= '0;
    end else begin
      partial_r <= partial_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ----- hdl/smxh_back.sv -----
// Back end: owns the accumulator and runs the multiply/xorshift mix over its idle and mix states.
// Depends on smxh_pkg for constants and the entry type.
module smxh_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  smxh_pkg::smxh_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_hash_value
);
  import smxh_pkg::*;

  typedef enum logic {
    BK_IDLE,
    BK_MIX
  } back_state_t;

  back_state_t       state_r;
  logic [WORD_W-1:0] acc_r;
  logic              final_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_hash_r;

  // Low 64 bits of the product split into three 32x32 partial products.
  logic [63:0]       p_ll_r, p_ll_nxt;
  logic [31:0]       p_hl_r, p_hl_nxt;
  logic [31:0]       p_lh_r, p_lh_nxt;

  logic [WORD_W-1:0] mix_in;
  logic [WORD_W-1:0] mult;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] mixed;
  logic              out_free;
  logic              load_digest;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign out_free       = !out_valid_r || !out_stall;
  assign q_pop          = (state_r == BK_IDLE) && !q_empty;
  assign load_digest    = (state_r == BK_MIX) && final_r && out_free;
  assign out_valid_nxt  = load_digest || (out_valid_r && out_stall);

  always_comb begin
    mix_in   = acc_r ^ q_entry.data;
    mult     = (q_entry.op == OP_MIX_FINAL) ? FINAL_MULT : WORD_MULT;
    p_ll_nxt = mix_in[31:0] * mult[31:0];
    p_hl_nxt = mix_in[63:32] * mult[31:0];
    p_lh_nxt = mix_in[31:0] * mult[63:32];
    prod     = p_ll_r + {32'(p_hl_r + p_lh_r), 32'd0};
    mixed    = prod ^ (prod >> MIX_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      acc_r       <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        BK_IDLE: begin
          if (!q_empty) begin
            case (q_entry.op) inside
              OP_START: begin
                acc_r <= q_entry.data;
              end
              OP_MIX_WORD, OP_MIX_FINAL: begin
                p_ll_r  <= p_ll_nxt;
                p_hl_r  <= p_hl_nxt;
                p_lh_r  <= p_lh_nxt;
                final_r <= (q_entry.op == OP_MIX_FINAL);
                state_r <= BK_MIX;
              end
              default: begin
              end
            endcase
          end
        end
        BK_MIX: begin
          // A digest waits here until the output register is free.
          if (!final_r || out_free) begin
            acc_r   <= mixed;
            state_r <= BK_IDLE;
            if (final_r) begin
              out_hash_r <= mixed;
            end
          end
        end
        default: begin
          state_r <= BK_IDLE;
        end
      endcase
    end
  end

endmodule
